// ----- rtl/core/lzw_variable_width_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// lzw variable width decoder assertion macros
// shared assertion wrappers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef LZW_VARIABLE_WIDTH_DECODER_DEFINES_SVH
`define LZW_VARIABLE_WIDTH_DECODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LVWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LVWD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LVWD_ASSERT(lbl, prop, msg)
`define LVWD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/core/lvwd_pkg.sv -----
// ----------------------------------------------------------------------------
// lvwd_pkg
// types and constants of the lzw variable width decoder
// ----------------------------------------------------------------------------
package lvwd_pkg;

  localparam int DICT_ENTRIES   = 4096;
  localparam int ADDR_W         = $clog2(DICT_ENTRIES);
  localparam int DEPTH_W        = ADDR_W + 1;
  localparam int MIN_CODE_WIDTH = 9;
  localparam int MAX_CODE_WIDTH = 12;
  localparam int CHUNK_BYTES    = 64;
  localparam int CNT_W          = $clog2(CHUNK_BYTES + 1);
  localparam int DICT_W         = ADDR_W + 8;
  localparam int BUF_W          = MAX_CODE_WIDTH + 8;

  localparam logic [ADDR_W-1:0]  CLEAR_CODE = ADDR_W'(256);
  localparam logic [ADDR_W-1:0]  END_CODE   = ADDR_W'(257);
  localparam logic [DEPTH_W-1:0] FIRST_FREE = DEPTH_W'(258);
  localparam logic [ADDR_W-1:0]  LITERALS   = ADDR_W'(256);

  localparam logic [2:0] ST_DECODING  = 3'd0;
  localparam logic [2:0] ST_OK        = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_EARLY_END = 3'd4;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       final_byte;
  } in_req_t;

  typedef struct packed {
    logic [63:0] chunk_word_0;
    logic [63:0] chunk_word_1;
    logic [63:0] chunk_word_2;
    logic [63:0] chunk_word_3;
    logic [63:0] chunk_word_4;
    logic [63:0] chunk_word_5;
    logic [63:0] chunk_word_6;
    logic [63:0] chunk_word_7;
    logic [6:0]  byte_count;
    logic [2:0]  decode_status;
    logic        last_of_run;
  } out_req_t;

endpackage

// ----- rtl/core/lvwd_ram.sv -----
// ----------------------------------------------------------------------------
// lvwd_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lvwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/lzw_variable_width_decoder.sv -----
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder
// lsb-first lzw decoder, 9 to 12 bit codes, decoded bytes in 64 byte chunks
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_req_t  (stream_byte, final_byte)
//   out      output     out_valid/ out_stall out_req_t (chunk words, count, status)
//   cfg      input      cfg_wr_en            cfg_wr_data, expected_length
//
// a request that completes no code leaves the decoder idle; one that only
// ends the stream passes through the emit state. after the accept a decoded
// string walks the dictionary ram one entry per cycle (a literal needs no
// read), is sized for the output in the prep state, then each emitted byte
// is read from the stack ram in the pop_rd and pop_wr states, and each chunk
// leaves through the emit state. results wait in an output register; a
// stalled output holds the pop sequencer. rams need no clearing after reset.
// ----------------------------------------------------------------------------
`include "lzw_variable_width_decoder_defines.svh"

module lzw_variable_width_decoder
  import lvwd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_WALK_RD   = 8'b0000_0010,
    S_WALK_DATA = 8'b0000_0100,
    S_WALK_LIT  = 8'b0000_1000,
    S_PREP      = 8'b0001_0000,
    S_POP_RD    = 8'b0010_0000,
    S_POP_WR    = 8'b0100_0000,
    S_EMIT      = 8'b1000_0000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [BUF_W-1:0]         buf_r, buf_nxt;
  logic [4:0]               bcnt_r, bcnt_nxt;
  logic [3:0]               width_r, width_nxt;
  logic [DEPTH_W-1:0]       next_code_r, next_code_nxt;
  logic [ADDR_W-1:0]        old_code_r, old_code_nxt;
  logic                     prev_valid_r, prev_valid_nxt;
  logic [7:0]               old_head_r, old_head_nxt;
  logic [31:0]              bw_r, bw_nxt;
  logic                     finished_r, finished_nxt;
  logic [31:0]              expected_r;
  logic [ADDR_W-1:0]        code_r, code_nxt;
  logic [ADDR_W-1:0]        t_r, t_nxt;
  logic [DEPTH_W-1:0]       depth_r, depth_nxt;
  logic [DEPTH_W-1:0]       emit_r, emit_nxt;
  logic [DEPTH_W-1:0]       pos_r, pos_nxt;
  logic                     len_done_r, len_done_nxt;
  logic                     final_r, final_nxt;
  logic [CNT_W-1:0]         ccnt_r, ccnt_nxt;
  logic [CHUNK_BYTES*8-1:0] chunk_r, chunk_nxt;
  logic [2:0]               status_r, status_nxt;
  logic                     last_r, last_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_req_t                 out_data_r, out_data_nxt;

  logic              dict_we;
  logic [ADDR_W-1:0] dict_waddr, dict_raddr;
  logic [DICT_W-1:0] dict_wdata, dict_rdata;
  logic              stk_we;
  logic [ADDR_W-1:0] stk_waddr, stk_raddr;
  logic [7:0]        stk_wdata, stk_rdata;

  logic [BUF_W-1:0]  buf_sum;
  logic [4:0]        bcnt8;
  logic [BUF_W-1:0]  mask;
  logic [ADDR_W-1:0] code_in;
  logic [ADDR_W-1:0] parent;
  logic [31:0]       remain;
  logic              load_out;
  logic [DEPTH_W-1:0] grow_lim;

  lvwd_ram #(.WIDTH(DICT_W), .DEPTH(DICT_ENTRIES)) u_dict (
    .clk     (clk),
    .wr_en   (dict_we),
    .wr_addr (dict_waddr),
    .wr_data (dict_wdata),
    .rd_addr (dict_raddr),
    .rd_data (dict_rdata)
  );

  lvwd_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load_out  = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  assign buf_sum  = buf_r | (BUF_W'(in_data.stream_byte) << bcnt_r);
  assign bcnt8    = bcnt_r + 5'd8;
  assign mask     = (BUF_W'(1) << width_r) - BUF_W'(1);
  assign code_in  = ADDR_W'(buf_sum & mask);
  assign parent   = dict_rdata[DICT_W-1:8];
  assign remain   = expected_r - bw_r;
  assign grow_lim = DEPTH_W'(1) << width_r;

  assign dict_raddr = (state_r == S_WALK_DATA) ? parent : t_r;
  assign stk_raddr  = ADDR_W'(depth_r - DEPTH_W'(1) - pos_r);

  always_comb begin
    state_nxt      = state_r;
    buf_nxt        = buf_r;
    bcnt_nxt       = bcnt_r;
    width_nxt      = width_r;
    next_code_nxt  = next_code_r;
    old_code_nxt   = old_code_r;
    prev_valid_nxt = prev_valid_r;
    old_head_nxt   = old_head_r;
    bw_nxt         = bw_r;
    finished_nxt   = finished_r;
    code_nxt       = code_r;
    t_nxt          = t_r;
    depth_nxt      = depth_r;
    emit_nxt       = emit_r;
    pos_nxt        = pos_r;
    len_done_nxt   = len_done_r;
    final_nxt      = final_r;
    ccnt_nxt       = ccnt_r;
    chunk_nxt      = chunk_r;
    status_nxt     = status_r;
    last_nxt       = last_r;
    dict_we        = 1'b0;
    dict_waddr     = next_code_r[ADDR_W-1:0];
    dict_wdata     = {old_code_r, t_r[7:0]};
    stk_we         = 1'b0;
    stk_waddr      = depth_r[ADDR_W-1:0];
    stk_wdata      = t_r[7:0];
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !finished_r) begin
          if (bw_r >= expected_r) begin
            finished_nxt = 1'b1;
            status_nxt   = ST_OK;
            last_nxt     = 1'b1;
            state_nxt    = S_EMIT;
          end else if (bcnt8 >= {1'b0, width_r}) begin
            buf_nxt  = buf_sum >> width_r;
            bcnt_nxt = bcnt8 - {1'b0, width_r};
            code_nxt = code_in;
            priority if (code_in == CLEAR_CODE) begin
              width_nxt      = 4'(MIN_CODE_WIDTH);
              next_code_nxt  = FIRST_FREE;
              prev_valid_nxt = 1'b0;
              if (in_data.final_byte) begin
                finished_nxt = 1'b1;
                status_nxt   = ST_TRUNC;
                last_nxt     = 1'b1;
                state_nxt    = S_EMIT;
              end
            end else if (code_in == END_CODE) begin
              finished_nxt = 1'b1;
              status_nxt   = ST_EARLY_END;
              last_nxt     = 1'b1;
              state_nxt    = S_EMIT;
            end else if ({1'b0, code_in} < next_code_r) begin
              final_nxt = in_data.final_byte;
              t_nxt     = code_in;
              depth_nxt = '0;
              state_nxt = (code_in < LITERALS) ? S_WALK_LIT : S_WALK_RD;
            end else if (({1'b0, code_in} == next_code_r) && prev_valid_r) begin
              final_nxt = in_data.final_byte;
              stk_we    = 1'b1;
              stk_waddr = '0;
              stk_wdata = old_head_r;
              t_nxt     = old_code_r;
              depth_nxt = DEPTH_W'(1);
              state_nxt = (old_code_r < LITERALS) ? S_WALK_LIT : S_WALK_RD;
            end else begin
              finished_nxt = 1'b1;
              status_nxt   = ST_INVALID;
              last_nxt     = 1'b1;
              state_nxt    = S_EMIT;
            end
          end else begin
            buf_nxt  = buf_sum;
            bcnt_nxt = bcnt8;
            if (in_data.final_byte) begin
              finished_nxt = 1'b1;
              status_nxt   = ST_TRUNC;
              last_nxt     = 1'b1;
              state_nxt    = S_EMIT;
            end
          end
        end
      end
      S_WALK_RD: begin
        state_nxt = S_WALK_DATA;
      end
      S_WALK_DATA: begin
        stk_we    = 1'b1;
        stk_wdata = dict_rdata[7:0];
        depth_nxt = depth_r + DEPTH_W'(1);
        t_nxt     = parent;
        if (parent < LITERALS) begin
          state_nxt = S_WALK_LIT;
        end
      end
      S_WALK_LIT: begin
        stk_we         = 1'b1;
        depth_nxt      = depth_r + DEPTH_W'(1);
        if (prev_valid_r && (next_code_r < DEPTH_W'(DICT_ENTRIES))) begin
          dict_we       = 1'b1;
          next_code_nxt = next_code_r + DEPTH_W'(1);
          if ((next_code_r + DEPTH_W'(1) >= grow_lim) &&
              (width_r < 4'(MAX_CODE_WIDTH))) begin
            width_nxt = width_r + 4'd1;
          end
        end
        old_code_nxt   = code_r;
        prev_valid_nxt = 1'b1;
        old_head_nxt   = t_r[7:0];
        state_nxt      = S_PREP;
      end
      S_PREP: begin
        if ({{(32-DEPTH_W){1'b0}}, depth_r} >= remain) begin
          emit_nxt     = remain[DEPTH_W-1:0];
          len_done_nxt = 1'b1;
          bw_nxt       = expected_r;
        end else begin
          emit_nxt     = depth_r;
          len_done_nxt = 1'b0;
          bw_nxt       = bw_r + {{(32-DEPTH_W){1'b0}}, depth_r};
        end
        pos_nxt   = '0;
        state_nxt = S_POP_RD;
      end
      S_POP_RD: begin
        state_nxt = S_POP_WR;
      end
      S_POP_WR: begin
        chunk_nxt[ccnt_r[CNT_W-2:0]*8 +: 8] = stk_rdata;
        ccnt_nxt = ccnt_r + CNT_W'(1);
        pos_nxt  = pos_r + DEPTH_W'(1);
        if (pos_r + DEPTH_W'(1) == emit_r) begin
          last_nxt = 1'b1;
          priority if (len_done_r) begin
            status_nxt   = ST_OK;
            finished_nxt = 1'b1;
          end else if (final_r) begin
            status_nxt   = ST_TRUNC;
            finished_nxt = 1'b1;
          end else begin
            status_nxt = ST_DECODING;
          end
          state_nxt = S_EMIT;
        end else if (ccnt_r + CNT_W'(1) == CNT_W'(CHUNK_BYTES)) begin
          last_nxt   = 1'b0;
          status_nxt = ST_DECODING;
          state_nxt  = S_EMIT;
        end else begin
          state_nxt = S_POP_RD;
        end
      end
      S_EMIT: begin
        if (load_out) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.chunk_word_0  = chunk_r[0*64 +: 64];
          out_data_nxt.chunk_word_1  = chunk_r[1*64 +: 64];
          out_data_nxt.chunk_word_2  = chunk_r[2*64 +: 64];
          out_data_nxt.chunk_word_3  = chunk_r[3*64 +: 64];
          out_data_nxt.chunk_word_4  = chunk_r[4*64 +: 64];
          out_data_nxt.chunk_word_5  = chunk_r[5*64 +: 64];
          out_data_nxt.chunk_word_6  = chunk_r[6*64 +: 64];
          out_data_nxt.chunk_word_7  = chunk_r[7*64 +: 64];
          out_data_nxt.byte_count    = 7'(ccnt_r);
          out_data_nxt.decode_status = last_r ? status_r : ST_DECODING;
          out_data_nxt.last_of_run   = last_r;
          chunk_nxt                  = '0;
          ccnt_nxt                   = '0;
          state_nxt                  = last_r ? S_IDLE : S_POP_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      buf_r        <= '0;
      bcnt_r       <= '0;
      width_r      <= 4'(MIN_CODE_WIDTH);
      next_code_r  <= FIRST_FREE;
      old_code_r   <= '0;
      prev_valid_r <= 1'b0;
      old_head_r   <= '0;
      bw_r         <= '0;
      finished_r   <= 1'b0;
      expected_r   <= '0;
      ccnt_r       <= '0;
      chunk_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      buf_r        <= buf_nxt;
      bcnt_r       <= bcnt_nxt;
      width_r      <= width_nxt;
      next_code_r  <= next_code_nxt;
      old_code_r   <= old_code_nxt;
      prev_valid_r <= prev_valid_nxt;
      old_head_r   <= old_head_nxt;
      bw_r         <= bw_nxt;
      finished_r   <= finished_nxt;
      if (cfg_wr_en) begin
        expected_r <= cfg_wr_data;
      end
      ccnt_r       <= ccnt_nxt;
      chunk_r      <= chunk_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r     <= code_nxt;
    t_r        <= t_nxt;
    depth_r    <= depth_nxt;
    emit_r     <= emit_nxt;
    pos_r      <= pos_nxt;
    len_done_r <= len_done_nxt;
    final_r    <= final_nxt;
    status_r   <= status_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  // chain walk never overruns the stack
  `LVWD_ASSERT(a_depth_bound, (state_r == S_WALK_DATA) |-> (depth_r < DEPTH_W'(DICT_ENTRIES)), "stack depth overrun")
  // pop stays within the emitted length
  `LVWD_ASSERT(a_pop_bound, (state_r == S_POP_RD) |-> (pos_r < emit_r), "pop past emit length")
  // chunk fill never exceeds one chunk
  `LVWD_ASSERT(a_chunk_bound, ccnt_r <= CNT_W'(CHUNK_BYTES), "chunk overfill")
  // a new result only loads from the emit state
  `LVWD_ASSERT(a_load_src, (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == S_EMIT), "result without emit")
  // reset returns the sequencer to idle
  `LVWD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "reset not idle")

endmodule

// ----- bench/lzw_variable_width_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder_tb
// builds lsb-first lzw code streams, drives them byte by byte with random
// gaps and output stalls, and checks every decoded chunk against a local
// decoder model; the run ends on one randomly chosen stream ending
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder_tb;
  import lvwd_pkg::*;

  localparam int LIMIT = 400000;
  localparam int DRAIN = 200;

  typedef enum {ENDING_LENGTH, ENDING_TRUNC, ENDING_BAD, ENDING_EARLY} ending_e;

  class chunk_scoreboard;
    logic [19:0] dict [DICT_ENTRIES];
    int unsigned bit_buf, bit_cnt, width, next_free, old_code, old_head;
    bit prev_valid, finished;
    logic [31:0] length_goal, written;
    out_req_t pending[$];
    int errors;

    function new();
      bit_buf = 0; bit_cnt = 0; width = MIN_CODE_WIDTH; next_free = 32'(FIRST_FREE);
      old_code = 0; old_head = 0; prev_valid = 0; finished = 0;
      length_goal = 0; written = 0; errors = 0;
    endfunction

    function void expand(int unsigned code, ref logic [7:0] s[$]);
      int unsigned t;
      t = code;
      while (t >= LITERALS) begin
        s.push_front(dict[t][7:0]);
        t = 32'(dict[t] >> 8);
      end
      s.push_front(t[7:0]);
    endfunction

    function void note_request(in_req_t r);
      logic [2:0] status;
      logic [7:0] s[$];
      logic [511:0] flat;
      out_req_t chunks[$];
      out_req_t c;
      int unsigned code, emit, pos, take;
      if (finished) return;
      status = ST_DECODING;
      emit = 0;
      if (written >= length_goal) begin
        finished = 1;
        status = ST_OK;
      end else begin
        bit_buf |= int'(r.stream_byte) << bit_cnt;
        bit_cnt += 8;
        if (bit_cnt >= width) begin
          code = bit_buf & ((1 << width) - 1);
          bit_buf >>= width;
          bit_cnt -= width;
          if (code == CLEAR_CODE) begin
            width = MIN_CODE_WIDTH; next_free = 32'(FIRST_FREE); prev_valid = 0;
          end else if (code == END_CODE) begin
            finished = 1;
            status = ST_EARLY_END;
          end else if (code < next_free || (code == next_free && prev_valid)) begin
            if (code < next_free) expand(code, s);
            else begin
              expand(old_code, s);
              s.push_back(old_head[7:0]);
            end
            emit = s.size();
            if (length_goal - written < emit) emit = length_goal - written;
            if (prev_valid && next_free < DICT_ENTRIES) begin
              dict[next_free] = {old_code[11:0], s[0]};
              next_free++;
              if (next_free >= (1 << width) && width < MAX_CODE_WIDTH) width++;
            end
            old_code = code;
            prev_valid = 1;
            old_head = 32'(s[0]);
          end else begin
            finished = 1;
            status = ST_INVALID;
          end
        end
      end
      pos = 0;
      do begin
        take = emit - pos;
        if (take > CHUNK_BYTES) take = CHUNK_BYTES;
        flat = '0;
        for (int i = 0; i < take; i++) flat[8*i +: 8] = s[pos + i];
        c = '0;
        c.chunk_word_0 = flat[63:0];    c.chunk_word_1 = flat[127:64];
        c.chunk_word_2 = flat[191:128]; c.chunk_word_3 = flat[255:192];
        c.chunk_word_4 = flat[319:256]; c.chunk_word_5 = flat[383:320];
        c.chunk_word_6 = flat[447:384]; c.chunk_word_7 = flat[511:448];
        c.byte_count = 7'(take);
        pos += take;
        written += take;
        chunks.push_back(c);
      end while (pos < emit);
      if (!finished) begin
        if (written >= length_goal) begin
          finished = 1;
          status = ST_OK;
        end else if (r.final_byte) begin
          finished = 1;
          status = ST_TRUNC;
        end
      end
      if (emit == 0 && status == ST_DECODING) return;
      chunks[chunks.size()-1].decode_status = status;
      chunks[chunks.size()-1].last_of_run = 1'b1;
      foreach (chunks[i]) pending.push_back(chunks[i]);
    endfunction

    function bit field_ok(string name, logic [63:0] e, logic [63:0] a);
      if (e === a) return 1;
      if (errors < 10) $display("field %s: expected %h, got %h", name, e, a);
      return 0;
    endfunction

    function void check_result(out_req_t got);
      out_req_t e;
      bit ok;
      if (pending.size() == 0) begin
        if (errors < 10) $display("unexpected result %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      ok = 1;
      ok &= field_ok("chunk_word_0", e.chunk_word_0, got.chunk_word_0);
      ok &= field_ok("chunk_word_1", e.chunk_word_1, got.chunk_word_1);
      ok &= field_ok("chunk_word_2", e.chunk_word_2, got.chunk_word_2);
      ok &= field_ok("chunk_word_3", e.chunk_word_3, got.chunk_word_3);
      ok &= field_ok("chunk_word_4", e.chunk_word_4, got.chunk_word_4);
      ok &= field_ok("chunk_word_5", e.chunk_word_5, got.chunk_word_5);
      ok &= field_ok("chunk_word_6", e.chunk_word_6, got.chunk_word_6);
      ok &= field_ok("chunk_word_7", e.chunk_word_7, got.chunk_word_7);
      ok &= field_ok("byte_count", 64'(e.byte_count), 64'(got.byte_count));
      ok &= field_ok("decode_status", 64'(e.decode_status), 64'(got.decode_status));
      ok &= field_ok("last_of_run", 64'(e.last_of_run), 64'(got.last_of_run));
      if (!ok) errors++;
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_wr_en;
  logic [31:0] cfg_wr_data;
  in_req_t in_data;
  out_req_t out_data;

  lzw_variable_width_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  chunk_scoreboard sb = new();
  bit quiet = 0, hold_req = 0, mark_final = 0;
  int cycles = 0, stall_left = 0, calm_left = 0;
  int unsigned enc_width = MIN_CODE_WIDTH, enc_next = 32'(FIRST_FREE);
  int unsigned enc_acc = 0, enc_bits = 0;
  bit enc_prev_valid = 0;

  initial begin
    clk = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
  end

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // output stall: random short bursts, calm stretches, one long hold on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req <= 0;
      stall_left <= 300;
      out_stall <= 1;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall <= 0;
    end else if (calm_left > 0) begin
      calm_left <= calm_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 3) begin
      calm_left <= $urandom_range(20, 80);
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(1, 3);
      out_stall <= 1;
    end
  end

  task automatic send_byte(logic [7:0] b, logic fin);
    in_req_t r;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    r.stream_byte = b;
    r.final_byte = fin;
    in_valid <= 1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
  endtask

  task automatic put_code(int unsigned c);
    bit good;
    good = c != CLEAR_CODE && c != END_CODE &&
           (c < enc_next || (c == enc_next && enc_prev_valid));
    enc_acc |= c << enc_bits;
    enc_bits += enc_width;
    while (enc_bits >= 8) begin
      send_byte(enc_acc[7:0], mark_final);
      mark_final = 0;
      enc_acc >>= 8;
      enc_bits -= 8;
    end
    if (c == CLEAR_CODE) begin
      enc_width = MIN_CODE_WIDTH; enc_next = 32'(FIRST_FREE); enc_prev_valid = 0;
    end else if (good) begin
      if (enc_prev_valid && enc_next < DICT_ENTRIES) begin
        enc_next++;
        if (enc_next >= (1 << enc_width) && enc_width < MAX_CODE_WIDTH) enc_width++;
      end
      enc_prev_valid = 1;
    end
  endtask

  task automatic put_random_code();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) put_code(32'(CLEAR_CODE));
    else if (r < 45 || enc_next == FIRST_FREE) put_code($urandom_range(0, 255));
    else if (r < 55 && enc_prev_valid) put_code(enc_next);
    else if (enc_next - FIRST_FREE > 20) put_code($urandom_range(enc_next - 20, enc_next - 1));
    else put_code($urandom_range(32'(FIRST_FREE), enc_next - 1));
  endtask

  task automatic settle();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_length(logic [31:0] v);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.length_goal = v;
    cfg_wr_en <= 0;
    @(posedge clk);
  endtask

  initial begin
    ending_e ending;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    write_length(32'h0);
    write_length(32'hFFFF_FFFF);

    // literal extremes, clear, repeated-entry codes and a growing chain
    put_code(32'(CLEAR_CODE));
    put_code(32'hFF);
    put_code(32'h00);
    put_code(enc_next);
    put_code(enc_next - 1);
    put_code(32'hA5);
    put_code(enc_next);
    put_code(enc_next);
    put_code(enc_next);
    put_code(enc_next - 1);
    put_code(32'(CLEAR_CODE));
    put_code(32'h5A);
    put_code(enc_next);
    put_code(32'(FIRST_FREE));

    hold_req <= 1;
    repeat (130) put_random_code();
    settle();
    write_length(32'h8000_0000);
    repeat (100) put_random_code();
    quiet = 1;
    repeat (20) put_random_code();

    ending = ending_e'($urandom_range(0, 3));
    case (ending)
      ENDING_LENGTH: begin
        settle();
        write_length(sb.written + $urandom_range(0, 40));
        while (!sb.finished) put_random_code();
      end
      ENDING_TRUNC: begin
        mark_final = 1;
        put_random_code();
      end
      ENDING_BAD: begin
        put_code(32'(CLEAR_CODE));
        put_code(32'(FIRST_FREE));
      end
      default: put_code(32'(END_CODE));
    endcase
    if (enc_bits > 0) send_byte(enc_acc[7:0], 1'b0);
    repeat (4) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    settle();

    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/lvwd_pkg.sv
rtl/core/lvwd_ram.sv
rtl/core/lzw_variable_width_decoder.sv
bench/lzw_variable_width_decoder_tb.sv
